// ----- design/trqd_pkg.sv -----
package trqd_pkg;

	localparam int TASK_COUNT = 255;
	localparam int ID_W       = 8;
	localparam int SLOT_W     = 8;
	localparam int LINK_DEPTH = 256;

	typedef enum logic [1:0] {
		OP_POST_TAIL = 2'd0,
		OP_POST_HEAD = 2'd1,
		OP_POP       = 2'd2,
		OP_NOP       = 2'd3
	} op_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	typedef struct packed {
		logic capture;
		logic commit;
	} cmd_t;

endpackage

// ----- design/task_ready_queue_dedup_top.sv -----
// channel | valid     | stall     | payload
// input   | in_valid  | in_stall  | opcode, task_id
// output  | out_valid | out_stall | was_queued, pop_valid, popped_task
//
// Each transfer first reads the link RAM (registered read) in the idle state,
// then in the exec state updates head/tail, writes the link RAM and loads the result register.
// A stalled result holds the exec state until the result register frees.
// Reset clears head, tail and the per-entry link valid bits; no clearing pass.
module task_ready_queue_dedup_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                opcode,
	input  logic [trqd_pkg::ID_W-1:0] task_id,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      was_queued,
	output logic                      pop_valid,
	output logic [trqd_pkg::ID_W-1:0] popped_task
);

	trqd_pkg::cmd_t cmd;

	trqd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	trqd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.opcode      (opcode),
		.task_id     (task_id),
		.was_queued  (was_queued),
		.pop_valid   (pop_valid),
		.popped_task (popped_task)
	);

endmodule

// ----- design/trqd_ram.sv -----
module trqd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/trqd_ctrl.sv -----
module trqd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output trqd_pkg::cmd_t cmd
);

	trqd_pkg::state_t state_q, state_d;
	logic             out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= trqd_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		in_stall    = 1'b1;
		unique case (state_q)
			trqd_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = trqd_pkg::ST_EXEC;
				end
			end
			trqd_pkg::ST_EXEC: begin
				// result register must be free or draining
				if (!out_valid_q || !out_stall) begin
					cmd.commit = 1'b1;
					state_d    = trqd_pkg::ST_IDLE;
				end
			end
			default: state_d = trqd_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- design/trqd_dp.sv -----
module trqd_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  trqd_pkg::cmd_t              cmd,
	input  logic [1:0]                  opcode,
	input  logic [trqd_pkg::ID_W-1:0]   task_id,
	output logic                        was_queued,
	output logic                        pop_valid,
	output logic [trqd_pkg::ID_W-1:0]   popped_task
);

	logic [1:0]                  op_q;
	logic [trqd_pkg::SLOT_W-1:0] slot_q;
	logic                        inrange_q;
	logic [trqd_pkg::SLOT_W-1:0] head_q, tail_q;
	logic [trqd_pkg::SLOT_W-1:0] head_d, tail_d;
	logic [trqd_pkg::LINK_DEPTH-1:0] link_vld_q;
	logic                        rd_vld_q;

	logic [trqd_pkg::SLOT_W-1:0] in_slot;
	logic [trqd_pkg::SLOT_W-1:0] raddr;
	logic [trqd_pkg::SLOT_W-1:0] rdata;
	logic [trqd_pkg::SLOT_W-1:0] link;

	logic                        we;
	logic [trqd_pkg::SLOT_W-1:0] waddr, wdata;

	logic                        present_d, popv_d;
	logic [trqd_pkg::ID_W-1:0]   popped_d;
	logic                        present_q, popv_q;
	logic [trqd_pkg::ID_W-1:0]   popped_q;

	assign in_slot = trqd_pkg::SLOT_W'(task_id + 1'b1);
	assign raddr   = (trqd_pkg::op_t'(opcode) == trqd_pkg::OP_POP) ? head_q : in_slot;

	trqd_ram #(
		.WIDTH(trqd_pkg::SLOT_W),
		.DEPTH(trqd_pkg::LINK_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (cmd.capture),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign link = rd_vld_q ? rdata : '0;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= opcode;
			slot_q    <= in_slot;
			inrange_q <= ({1'b0, task_id} < 9'(trqd_pkg::TASK_COUNT));
		end
		if (cmd.commit) begin
			present_q <= present_d;
			popv_q    <= popv_d;
			popped_q  <= popped_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			link_vld_q <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			if (cmd.capture) begin
				rd_vld_q <= link_vld_q[raddr];
			end
			if (cmd.commit) begin
				head_q <= head_d;
				tail_q <= tail_d;
			end
			if (we) begin
				link_vld_q[waddr] <= 1'b1;
			end
		end
	end

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		we        = 1'b0;
		waddr     = slot_q;
		wdata     = '0;
		present_d = 1'b0;
		popv_d    = 1'b0;
		popped_d  = '0;
		unique case (trqd_pkg::op_t'(op_q))
			trqd_pkg::OP_POST_TAIL: begin
				if (inrange_q) begin
					if (tail_q == '0) begin
						head_d = slot_q;
						tail_d = slot_q;
					end else if (link != '0 || tail_q == slot_q) begin
						present_d = 1'b1;
					end else begin
						we     = cmd.commit;
						waddr  = tail_q;
						wdata  = slot_q;
						tail_d = slot_q;
					end
				end
			end
			trqd_pkg::OP_POST_HEAD: begin
				if (inrange_q) begin
					if (head_q == '0) begin
						head_d = slot_q;
						tail_d = slot_q;
					end else if (link != '0 || tail_q == slot_q) begin
						present_d = 1'b1;
					end else begin
						we     = cmd.commit;
						waddr  = slot_q;
						wdata  = head_q;
						head_d = slot_q;
					end
				end
			end
			trqd_pkg::OP_POP: begin
				if (head_q != '0) begin
					popv_d   = 1'b1;
					popped_d = trqd_pkg::ID_W'(head_q - 1'b1);
					head_d   = link;
					we       = cmd.commit;
					waddr    = head_q;
					wdata    = '0;
					if (link == '0) begin
						tail_d = '0;
					end
				end
			end
			trqd_pkg::OP_NOP: begin
			end
			default: begin
			end
		endcase
	end

	assign was_queued  = present_q;
	assign pop_valid   = popv_q;
	assign popped_task = popped_q;

endmodule
